[src/bse_pkg.sv]
// Package for the byte entropy block: widths, constants, payload structs.
// Used by the stream interfaces and by byte_shannon_entropy.
package bse_pkg;

  localparam int unsigned NUM_BINS        = 256;
  localparam int unsigned BIN_W           = 8;
  localparam int unsigned MAX_BLOCK_BYTES = 65536;
  localparam int unsigned CNT_W           = 17;
  localparam int unsigned FRACTION_BITS   = 16;
  localparam int unsigned LOG_FRAC        = 28;
  localparam int unsigned MANT_FRAC       = 30;
  localparam int unsigned IP_W            = 5;
  localparam int unsigned LOG_W           = IP_W + LOG_FRAC;
  localparam int unsigned PROD_W          = CNT_W + LOG_W;
  localparam int unsigned ENT_W           = 20;
  localparam int unsigned RND_SH          = LOG_FRAC - FRACTION_BITS;
  localparam int unsigned STEP_W          = 6;

  typedef struct packed {
    logic [BIN_W-1:0] data_byte;
    logic             is_last;
  } in_word_t;

  typedef struct packed {
    logic [ENT_W-1:0] entropy_bits;
    logic [CNT_W-1:0] byte_total;
    logic             too_long;
  } out_word_t;

endpackage

[src/bse_in_if.sv]
// Input stream interface: one byte word per handshake.
// Depends on bse_pkg.
interface bse_in_if;
  logic                 valid;
  logic                 ready;
  logic [bse_pkg::BIN_W-1:0] data_byte;
  logic                 is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

[src/bse_out_if.sv]
// Result stream interface: entropy, byte count and overflow flag.
// Depends on bse_pkg.
interface bse_out_if;
  logic                      valid;
  logic                      ready;
  logic [bse_pkg::ENT_W-1:0] entropy_bits;
  logic [bse_pkg::CNT_W-1:0] byte_total;
  logic                      too_long;

  modport source (output valid, output entropy_bits, output byte_total, output too_long,
                  input ready);
  modport sink   (input valid, input entropy_bits, input byte_total, input too_long,
                  output ready);
endinterface

[src/byte_shannon_entropy.sv]
// Byte-block Shannon entropy. Each byte is a histogram memory read, then a
// write of the incremented bin; bytes past 65536 only set the overflow flag.
// After the last byte a sweep of the 256 bins runs: an empty or single-count
// bin is only read; others take 28 rounds of the shared squaring unit for
// log2, a multiply and an accumulate. Then one log2 of the count runs, and a
// 50-step bit-serial divide. Entropy is Q4.16 bits per byte. The input is not
// ready during the sweep; a result waits in the output register while the
// next block loads.
// Depends on bse_pkg, bse_in_if, bse_out_if.
module byte_shannon_entropy (
  input  logic      clk_i,
  input  logic      rst_ni,
  bse_in_if.sink    byte_i,
  bse_out_if.source ent_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_INC  = 9'b000000010,
    S_SRD  = 9'b000000100,
    S_SLD  = 9'b000001000,
    S_LOG  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  localparam logic [bse_pkg::CNT_W-1:0] MaxCnt = bse_pkg::CNT_W'(bse_pkg::MAX_BLOCK_BYTES);
  localparam logic [bse_pkg::PROD_W-1:0] EntLimit =
    bse_pkg::PROD_W'(8) << bse_pkg::FRACTION_BITS;

  state_e state_q, state_d;

  // histogram memory with per-entry valid bits
  logic [bse_pkg::CNT_W-1:0]    mem [bse_pkg::NUM_BINS];
  logic [bse_pkg::CNT_W-1:0]    rd_q;
  logic [bse_pkg::BIN_W-1:0]    rd_addr;
  logic [bse_pkg::NUM_BINS-1:0] vld_q;

  logic [bse_pkg::BIN_W-1:0]  addr_q, bin_q;
  logic                       last_q, too_long_q, is_n_q;
  logic [bse_pkg::CNT_W-1:0]  cnt_q;

  // log2 unit state
  logic [bse_pkg::CNT_W-1:0]     x_q;
  logic [bse_pkg::MANT_FRAC:0]   m_q;
  logic [bse_pkg::LOG_FRAC-1:0]  frac_q;
  logic [bse_pkg::IP_W-1:0]      ip_q;
  logic [bse_pkg::STEP_W-1:0]    step_q;

  logic [bse_pkg::PROD_W-1:0] prod_q, sum_q, div_q;
  logic [bse_pkg::CNT_W:0]    rem_q;

  logic                      out_vld_q;
  bse_pkg::out_word_t        out_q;

  logic                      accept, out_free;
  logic [bse_pkg::CNT_W-1:0] bin_cnt;

  assign accept   = byte_i.valid && byte_i.ready;
  assign out_free = !out_vld_q || ent_o.ready;
  assign bin_cnt  = vld_q[bin_q] ? rd_q : '0;
  assign byte_i.ready = (state_q == S_IDLE);
  assign rd_addr  = (state_q == S_IDLE) ? byte_i.data_byte : bin_q;

  // memory: registered read, one write port
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (state_q == S_INC) begin
      mem[addr_q] <= (vld_q[addr_q] ? rd_q : '0) + bse_pkg::CNT_W'(1);
    end
  end

  // leading-one position of a load value, used to form its Q30 mantissa
  logic [bse_pkg::CNT_W-1:0]  ld_x;
  logic [bse_pkg::IP_W-1:0]   ld_ip;
  always_comb begin
    ld_ip = '0;
    for (int i = 0; i < bse_pkg::CNT_W; i++) begin
      if (ld_x[i]) ld_ip = bse_pkg::IP_W'(i);
    end
  end

  // squaring unit
  logic [2*bse_pkg::MANT_FRAC+1:0] sq;
  logic [bse_pkg::MANT_FRAC+1:0]   msq;
  assign sq  = (2*bse_pkg::MANT_FRAC+2)'(m_q) * (2*bse_pkg::MANT_FRAC+2)'(m_q);
  assign msq = sq[2*bse_pkg::MANT_FRAC+1:bse_pkg::MANT_FRAC];

  // divider trial step
  logic [bse_pkg::CNT_W:0] trial;
  assign trial = {rem_q[bse_pkg::CNT_W-1:0], div_q[bse_pkg::PROD_W-1]};

  // rounding of the quotient
  logic [bse_pkg::PROD_W-1:0] h_rnd;
  assign h_rnd = (div_q + (bse_pkg::PROD_W'(1) << (bse_pkg::RND_SH - 1))) >> bse_pkg::RND_SH;

  // sequencer next state and log load selection
  logic ld_log;
  always_comb begin
    state_d = state_q;
    ld_log  = 1'b0;
    ld_x    = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cnt_q < MaxCnt) state_d = S_INC;
          else if (byte_i.is_last) state_d = S_SRD;
        end
      end
      S_INC: state_d = last_q ? S_SRD : S_IDLE;
      S_SRD: state_d = S_SLD;
      S_SLD: begin
        if (bin_cnt > bse_pkg::CNT_W'(1)) begin
          ld_log = 1'b1;
          ld_x   = bin_cnt;
          state_d = S_LOG;
        end else if (bin_q == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) begin
          ld_log = 1'b1;
          state_d = S_LOG;
        end else begin
          state_d = S_SRD;
        end
      end
      S_LOG: if (step_q == bse_pkg::STEP_W'(bse_pkg::LOG_FRAC - 1)) state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        if (is_n_q) begin
          state_d = S_DIV;
        end else if (bin_q == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) begin
          ld_log = 1'b1;
          state_d = S_LOG;
        end else begin
          state_d = S_SRD;
        end
      end
      S_DIV: if (step_q == bse_pkg::STEP_W'(bse_pkg::PROD_W - 1)) state_d = S_FIN;
      S_FIN: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      vld_q      <= '0;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
      out_vld_q  <= 1'b0;
      bin_q      <= '0;
      is_n_q     <= 1'b0;
      step_q     <= '0;
    end else begin
      state_q <= state_d;
      // result word: loaded at the end of a sweep, dropped once taken
      if (state_q == S_FIN && out_free) out_vld_q <= 1'b1;
      else if (ent_o.ready) out_vld_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          bin_q  <= '0;
          is_n_q <= 1'b0;
          if (accept && !(cnt_q < MaxCnt)) too_long_q <= 1'b1;
        end
        S_INC: begin
          vld_q[addr_q] <= 1'b1;
          cnt_q         <= cnt_q + bse_pkg::CNT_W'(1);
        end
        S_SLD: begin
          if (!(bin_cnt > bse_pkg::CNT_W'(1))) begin
            if (bin_q == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) is_n_q <= 1'b1;
            else bin_q <= bin_q + bse_pkg::BIN_W'(1);
          end
          step_q <= '0;
        end
        S_LOG: step_q <= step_q + bse_pkg::STEP_W'(1);
        S_MUL: step_q <= '0;
        S_ACC: begin
          if (!is_n_q) begin
            if (bin_q == bse_pkg::BIN_W'(bse_pkg::NUM_BINS - 1)) is_n_q <= 1'b1;
            else bin_q <= bin_q + bse_pkg::BIN_W'(1);
          end
        end
        S_DIV: step_q <= step_q + bse_pkg::STEP_W'(1);
        S_FIN: begin
          if (out_free) begin
            vld_q      <= '0;
            cnt_q      <= '0;
            too_long_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= byte_i.data_byte;
      last_q <= byte_i.is_last;
    end
    if (state_q == S_SRD && bin_q == '0) sum_q <= '0;
    if (ld_log) begin
      x_q    <= ld_x;
      ip_q   <= ld_ip;
      m_q    <= (bse_pkg::MANT_FRAC+1)'(ld_x) << (bse_pkg::MANT_FRAC - 32'(ld_ip));
      frac_q <= '0;
    end else if (state_q == S_LOG) begin
      if (msq[bse_pkg::MANT_FRAC+1]) begin
        m_q    <= msq[bse_pkg::MANT_FRAC+1:1];
        frac_q <= {frac_q[bse_pkg::LOG_FRAC-2:0], 1'b1};
      end else begin
        m_q    <= msq[bse_pkg::MANT_FRAC:0];
        frac_q <= {frac_q[bse_pkg::LOG_FRAC-2:0], 1'b0};
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= bse_pkg::PROD_W'(x_q) * bse_pkg::PROD_W'({ip_q, frac_q});
    end
    if (state_q == S_ACC) begin
      if (is_n_q) begin
        div_q <= (prod_q > sum_q) ? prod_q - sum_q : '0;
        rem_q <= '0;
      end else begin
        sum_q <= sum_q + prod_q;
      end
    end
    if (state_q == S_DIV) begin
      if (trial >= {1'b0, cnt_q}) begin
        rem_q <= trial - {1'b0, cnt_q};
        div_q <= {div_q[bse_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        div_q <= {div_q[bse_pkg::PROD_W-2:0], 1'b0};
      end
    end
    if (state_q == S_FIN && out_free) begin
      out_q.entropy_bits <= (h_rnd > EntLimit) ? EntLimit[bse_pkg::ENT_W-1:0]
                                               : h_rnd[bse_pkg::ENT_W-1:0];
      out_q.byte_total   <= cnt_q;
      out_q.too_long     <= too_long_q;
    end
  end

  assign ent_o.valid        = out_vld_q;
  assign ent_o.entropy_bits = out_q.entropy_bits;
  assign ent_o.byte_total   = out_q.byte_total;
  assign ent_o.too_long     = out_q.too_long;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("byte count above maximum");
  a_inc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INC |-> cnt_q < MaxCnt) else $error("bin increment on full block");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> vld_q == '0 && cnt_q == '0)
    else $error("histogram not cleared after result");

endmodule
